// ----- rtl/trs_pkg.sv -----
// Shared types and constants of the token ring station.
package trs_pkg;

  localparam int ID_BITS      = 16;
  localparam int PAYLOAD_BITS = 64;
  localparam int TTL_BITS     = 8;
  localparam int COUNT_BITS   = 32;
  localparam int ADDR_BITS    = 32;
  localparam int PORT_BITS    = 16;
  localparam int CFG_IDX_BITS = 8;
  localparam int CFG_DAT_BITS = 32;

  // Input item kinds
  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_SUBMIT = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  // Frame types on the ring
  localparam logic [2:0] FT_JOIN     = 3'd0;
  localparam logic [2:0] FT_JOIN_ACK = 3'd1;
  localparam logic [2:0] FT_FREE     = 3'd2;
  localparam logic [2:0] FT_FULL     = 3'd3;
  localparam logic [2:0] FT_RETURN   = 3'd4;

  // Result events
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_FORWARD   = 3'd1;
  localparam logic [2:0] EV_DELIVER   = 3'd2;
  localparam logic [2:0] EV_CONFIRM   = 3'd3;
  localparam logic [2:0] EV_TTL_DROP  = 3'd4;
  localparam logic [2:0] EV_JOIN_ACK  = 3'd5;
  localparam logic [2:0] EV_BUSY      = 3'd6;
  localparam logic [2:0] EV_ACCEPTED  = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_ID     = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INITIAL_TTL = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_TOKEN = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_ADDR  = 8'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_PORT  = 8'd4;

  typedef struct packed {
    logic [1:0]              kind;
    logic [2:0]              frame_type;
    logic [ID_BITS-1:0]      dest_id;
    logic [ID_BITS-1:0]      src_id;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [COUNT_BITS-1:0]   pass_count;
    logic [TTL_BITS-1:0]     ttl_in;
    logic [ADDR_BITS-1:0]    join_addr;
    logic [PORT_BITS-1:0]    join_hop_port;
    logic [ADDR_BITS-1:0]    sender_addr;
    logic [PORT_BITS-1:0]    sender_port;
  } trs_in_t;

  typedef struct packed {
    logic [2:0]              event_res;
    logic [2:0]              out_type;
    logic [ID_BITS-1:0]      out_dest;
    logic [ID_BITS-1:0]      out_source;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [COUNT_BITS-1:0]   out_count;
    logic [TTL_BITS-1:0]     out_ttl;
    logic [ADDR_BITS-1:0]    out_join_addr;
    logic [PORT_BITS-1:0]    out_join_port;
    logic [ADDR_BITS-1:0]    send_addr;
    logic [PORT_BITS-1:0]    send_port;
  } trs_out_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   node_id;
    logic [TTL_BITS-1:0]  initial_ttl;
    logic                 start_with_token;
    logic [ADDR_BITS-1:0] first_next_addr;
    logic [PORT_BITS-1:0] first_next_port;
  } trs_cfg_t;

endpackage

// ----- rtl/trs_if.sv -----
// Handshake channel interfaces of the token ring station.
interface trs_in_if;
  import trs_pkg::*;
  logic    valid;
  logic    ready;
  trs_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trs_out_if;
  import trs_pkg::*;
  logic     valid;
  logic     ready;
  trs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trs_cfg_if;
  import trs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [CFG_DAT_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/trs_cfg_regs.sv -----
// Configuration register file of the token ring station.
module trs_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  trs_cfg_if.sink           cfg,
  output trs_pkg::trs_cfg_t cfg_o
);
  import trs_pkg::*;

  trs_cfg_t regs_r;

  assign cfg.ready = 1'b1;
  assign cfg_o     = regs_r;

  // Write the addressed register on a transfer; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.node_id          <= '0;
      regs_r.initial_ttl      <= TTL_BITS'(3);
      regs_r.start_with_token <= 1'b0;
      regs_r.first_next_addr  <= '0;
      regs_r.first_next_port  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_NODE_ID:     regs_r.node_id          <= cfg.data[ID_BITS-1:0];
        CFG_INITIAL_TTL: regs_r.initial_ttl      <= cfg.data[TTL_BITS-1:0];
        CFG_START_TOKEN: regs_r.start_with_token <= cfg.data[0];
        CFG_FIRST_ADDR:  regs_r.first_next_addr  <= cfg.data[ADDR_BITS-1:0];
        CFG_FIRST_PORT:  regs_r.first_next_port  <= cfg.data[PORT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/trs_station.sv -----
// Station state, token processing logic and result register.
module trs_station (
  input  logic              clk,
  input  logic              rst_n,
  input  trs_pkg::trs_cfg_t cfg_i,
  input  logic              item_valid,
  input  trs_pkg::trs_in_t  item,
  output logic              item_take,
  trs_out_if.source         out
);
  import trs_pkg::*;

  logic [ADDR_BITS-1:0]    next_addr_r, next_addr_nxt;
  logic [PORT_BITS-1:0]    next_port_r, next_port_nxt;
  logic                    pending_valid_r, pending_valid_nxt;
  logic [ID_BITS-1:0]      pending_dest_r, pending_dest_nxt;
  logic [PAYLOAD_BITS-1:0] pending_payload_r, pending_payload_nxt;
  logic                    holding_token_r, holding_token_nxt;
  logic                    injected_r, injected_nxt;
  logic                    out_valid_r;
  trs_out_t                out_data_r, res;
  logic [TTL_BITS-1:0]     ttl_dec;
  logic [COUNT_BITS-1:0]   cnt_inc;
  logic                    to_me, from_me;

  // Take an item whenever the result register is free or being drained
  assign item_take = item_valid && (!out_valid_r || out.ready);
  assign out.valid = out_valid_r;
  assign out.data  = out_data_r;

  assign to_me   = (item.dest_id == cfg_i.node_id);
  assign from_me = (item.src_id == cfg_i.node_id);
  assign ttl_dec = (item.ttl_in != '0) ? item.ttl_in - TTL_BITS'(1) : '0;
  assign cnt_inc = item.pass_count + COUNT_BITS'(1);

  // Process one item: next state and the frame to send
  always_comb begin
    next_addr_nxt       = next_addr_r;
    next_port_nxt       = next_port_r;
    pending_valid_nxt   = pending_valid_r;
    pending_dest_nxt    = pending_dest_r;
    pending_payload_nxt = pending_payload_r;
    holding_token_nxt   = holding_token_r;
    injected_nxt        = injected_r;
    res                 = '0;

    unique case (item.kind)
      KIND_SUBMIT: begin
        if (pending_valid_r) begin
          res.event_res = EV_BUSY;
        end else begin
          pending_valid_nxt   = 1'b1;
          pending_dest_nxt    = item.dest_id;
          pending_payload_nxt = item.payload;
          res.event_res       = EV_ACCEPTED;
        end
      end
      KIND_START: begin
        next_addr_nxt     = cfg_i.first_next_addr;
        next_port_nxt     = cfg_i.first_next_port;
        holding_token_nxt = cfg_i.start_with_token;
        injected_nxt      = 1'b0;
        res.event_res     = EV_FORWARD;
        res.out_type      = FT_JOIN;
        res.send_addr     = cfg_i.first_next_addr;
        res.send_port     = cfg_i.first_next_port;
      end
      KIND_FRAME: begin
        // Frame defaults: copy the arriving fields, send on to the next hop
        res.out_type      = item.frame_type;
        res.out_dest      = item.dest_id;
        res.out_source    = item.src_id;
        res.out_payload   = item.payload;
        res.out_count     = item.pass_count;
        res.out_ttl       = item.ttl_in;
        res.out_join_addr = item.join_addr;
        res.out_join_port = item.join_hop_port;
        res.send_addr     = next_addr_r;
        res.send_port     = next_port_r;
        res.event_res     = EV_FORWARD;
        unique case (item.frame_type)
          FT_JOIN: begin
            // Splice the new station in after this one
            res.out_type      = FT_JOIN_ACK;
            res.out_join_addr = next_addr_r;
            res.out_join_port = next_port_r;
            res.send_addr     = item.sender_addr;
            res.send_port     = item.sender_port;
            res.event_res     = EV_JOIN_ACK;
            next_addr_nxt     = item.sender_addr;
            next_port_nxt     = item.sender_port;
          end
          FT_JOIN_ACK: begin
            next_addr_nxt = item.join_addr;
            next_port_nxt = item.join_hop_port;
            res           = '0;
            if (holding_token_r && !injected_r) begin
              injected_nxt      = 1'b1;
              holding_token_nxt = 1'b0;
              res.event_res     = EV_FORWARD;
              res.out_type      = FT_FREE;
              res.send_addr     = item.join_addr;
              res.send_port     = item.join_hop_port;
            end
          end
          FT_FREE: begin
            // Load the pending message, if any, onto the free token and pass it on
            holding_token_nxt = 1'b0;
            res.out_count     = cnt_inc;
            if (pending_valid_r) begin
              pending_valid_nxt   = 1'b0;
              pending_dest_nxt    = '0;
              pending_payload_nxt = '0;
              res.out_type        = FT_FULL;
              res.out_dest        = pending_dest_r;
              res.out_source      = cfg_i.node_id;
              res.out_payload     = pending_payload_r;
              res.out_ttl         = cfg_i.initial_ttl;
            end
          end
          FT_FULL: begin
            // Deliver first, then age the message at its sender
            holding_token_nxt = 1'b0;
            res.out_count     = cnt_inc;
            if (to_me) begin
              res.out_dest  = '0;
              res.out_type  = FT_RETURN;
              res.event_res = EV_DELIVER;
            end
            if (from_me) begin
              res.out_ttl = ttl_dec;
              if (ttl_dec == '0) begin
                res.out_dest    = '0;
                res.out_payload = '0;
                res.out_source  = '0;
                res.out_type    = FT_FREE;
                res.event_res   = EV_TTL_DROP;
              end
            end
          end
          FT_RETURN: begin
            // Confirm delivery back at the sender and free the token
            holding_token_nxt = 1'b0;
            if (from_me) begin
              res.out_source = '0;
              res.out_count  = cnt_inc;
              res.out_type   = FT_FREE;
              res.event_res  = EV_CONFIRM;
            end
          end
          default: begin
            res = '0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Update station state on each taken item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_addr_r       <= '0;
      next_port_r       <= '0;
      pending_valid_r   <= 1'b0;
      pending_dest_r    <= '0;
      pending_payload_r <= '0;
      holding_token_r   <= 1'b0;
      injected_r        <= 1'b0;
    end else if (item_take) begin
      next_addr_r       <= next_addr_nxt;
      next_port_r       <= next_port_nxt;
      pending_valid_r   <= pending_valid_nxt;
      pending_dest_r    <= pending_dest_nxt;
      pending_payload_r <= pending_payload_nxt;
      holding_token_r   <= holding_token_nxt;
      injected_r        <= injected_nxt;
    end
  end

  // Result register: load on take, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_take) begin
      out_valid_r <= 1'b1;
    end else if (out.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_data_r <= res;
    end
  end

endmodule

// ----- rtl/token_ring_station_step.sv -----
// Top level of one token ring station: input register, station logic, config.
//
// Channels: in_ch carries arriving frames, local message submissions and the
// start command; out_ch carries exactly one result per accepted item, which
// describes the frame sent (or event 0, busy or accepted with zero fields);
// cfg_ch writes the station id, initial TTL, start flag and first next hop.
// Config writes are taken in every cycle and must happen while the block is idle.
//
// Path: each accepted item passes through the input register, then is processed
// into the result register.
// Throughput: one item per cycle unless out_ch stalls; the station state is read
// and updated in the same cycle, so each item sees the state the prior one left.
//
// Reset clears the config registers to their defaults, empties both registers
// and clears the station state (next hop, pending slot, token flags).
// When out_ch stalls, the result register holds; the input register, if empty,
// still takes one more item, then in_ch.ready drops until the result is taken.
module token_ring_station_step (
  input logic       clk,
  input logic       rst_n,
  trs_in_if.sink    in_ch,
  trs_out_if.source out_ch,
  trs_cfg_if.sink   cfg_ch
);
  import trs_pkg::*;

  trs_cfg_t cfg;
  logic     in_valid_r;
  trs_in_t  in_data_r;
  logic     item_take;

  trs_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .cfg_o (cfg)
  );

  // Accept a new item when the input register is empty or moving on
  assign in_ch.ready = !in_valid_r || item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data_r <= in_ch.data;
    end
  end

  trs_station u_station (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .item_valid (in_valid_r),
    .item       (in_data_r),
    .item_take  (item_take),
    .out        (out_ch)
  );

endmodule
